// File: sv/lge_pkg.sv
`default_nettype none
package lge_pkg;
   localparam int MaxWidthDefault  = 128;
   localparam int MaxHeightDefault = 64;
   localparam int WidthRegBits     = 8;
   localparam int HeightRegBits    = 7;
   localparam int IndexBits        = 13;
   localparam int CountBits        = 4;
   localparam int CsrAddrBits      = 1;
   localparam int CsrDataBits      = 8;
   localparam logic [7:0] WidthReset  = 8'd120;
   localparam logic [6:0] HeightReset = 7'd40;
   localparam logic [3:0] BirthCount   = 4'd3;
   localparam logic [3:0] SurviveCount = 4'd2;

   typedef enum logic [1:0] {
      OP_SET     = 2'd0,
      OP_READ    = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [0:0] CSR_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_HEIGHT = 1'b1;

   // datapath command from controller
   typedef enum logic [2:0] {
      DP_IDLE,
      DP_CLEAR,     // write zero at scan address (reset sweep)
      DP_LOAD,      // latch item, set up position
      DP_NEIGH,     // issue neighbour read at scan step
      DP_CENTER,    // issue center read
      DP_WRITE_NEXT,// write next-gen bit at scan cell
      DP_COPY_RD,   // read next-gen at scan cell
      DP_COPY_WR    // write it back
   } dp_cmd_type;

   typedef struct packed {
      dp_cmd_type cmd;
      logic       step_first; // restart neighbour step counter
      logic       cell_first; // restart cell scan
      logic       cell_next;  // move scan to next cell
      logic       set_write;  // write set value to cell_store
      logic       div_step;   // one row of index to row/col reduction
   } ctl_type;

   typedef struct packed {
      logic clear_done;
      logic step_last;   // neighbour step counter at last step
      logic cell_last;   // scan at last cell
      logic bad_index;
      logic div_done;    // remaining index below width
   } sts_type;
endpackage
`default_nettype wire

// File: sv/lge_if.sv
`default_nettype none
interface lge_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      operation;
   logic [lge_pkg::IndexBits-1:0]   cell_index;
   logic                            cell_value;
   modport source (output valid, operation, cell_index, cell_value, input ready);
   modport sink   (input valid, operation, cell_index, cell_value, output ready);
endinterface

interface lge_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            cell_state;
   logic [lge_pkg::CountBits-1:0]   neighbour_count;
   logic                            index_error;
   modport source (output valid, cell_state, neighbour_count, index_error, input ready);
   modport sink   (input valid, cell_state, neighbour_count, index_error, output ready);
endinterface
`default_nettype wire

// File: sv/lge_ram.sv
`default_nettype none
module lge_ram #(
   parameter int Width = 1,
   parameter int Depth = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/lge_datapath.sv
`default_nettype none
module lge_datapath #(
   parameter int MaxWidth  = lge_pkg::MaxWidthDefault,
   parameter int MaxHeight = lge_pkg::MaxHeightDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire lge_pkg::ctl_type                   ctl,
   output lge_pkg::sts_type                        sts,
   input  wire logic [lge_pkg::IndexBits-1:0]      req_cell_index,
   input  wire logic                               req_cell_value,
   input  wire logic [lge_pkg::WidthRegBits-1:0]   width_reg,
   input  wire logic [lge_pkg::HeightRegBits-1:0]  height_reg,
   output logic                                    res_cell_state,
   output logic [lge_pkg::CountBits-1:0]           res_count
);
   localparam int Depth = MaxWidth * MaxHeight;
   localparam int AddrBits = $clog2(Depth);
   localparam int ColBits = $clog2(MaxWidth);
   localparam int RowBits = $clog2(MaxHeight);
   localparam int WBits = $clog2(MaxWidth + 1);
   localparam int HBits = $clog2(MaxHeight + 1);
   localparam int TotBits = WBits + HBits;
   localparam int IdxBits = lge_pkg::IndexBits;

   // clamp register values (combinational)
   logic [WBits-1:0] w_use;
   logic [HBits-1:0] h_use;
   logic [TotBits-1:0] total;
   always_comb begin
      if (width_reg == '0) w_use = WBits'(1);
      else if (32'(width_reg) > MaxWidth) w_use = WBits'(MaxWidth);
      else w_use = WBits'(width_reg);
      if (height_reg == '0) h_use = HBits'(1);
      else if (32'(height_reg) > MaxHeight) h_use = HBits'(MaxHeight);
      else h_use = HBits'(height_reg);
      total = TotBits'(w_use) * TotBits'(h_use);
   end

   // position: row/col of the item or of the scan cell, plus flat address
   logic [RowBits-1:0] row_ff, row_in;
   logic [ColBits-1:0] col_ff, col_in;
   logic [AddrBits-1:0] addr_ff, addr_in;
   logic [3:0] step_ff, step_in;
   logic [lge_pkg::CountBits-1:0] cnt_ff, cnt_in;
   logic center_ff, center_in;
   logic val_ff, val_in;
   logic bad_ff, bad_in;
   logic [IdxBits-1:0] idx_ff, idx_in;
   logic clr_done_ff, clr_done_in;
   // delayed read bookkeeping (read data arrives in the next cycle)
   logic rd_nb_ff, rd_nb_in, rd_ct_ff, rd_ct_in, rd_cp_ff, rd_cp_in;
   logic [AddrBits-1:0] cp_addr_ff, cp_addr_in;

   // index to row/col: one row subtracted per cycle
   logic div_done;
   always_comb div_done = 32'(idx_ff) < 32'(w_use);

   // neighbour offsets by step 0..7
   logic signed [1:0] dr, dc;
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin dr = -2'sd1; dc = -2'sd1; end
         3'd1: begin dr = -2'sd1; dc =  2'sd0; end
         3'd2: begin dr = -2'sd1; dc =  2'sd1; end
         3'd3: begin dr =  2'sd0; dc = -2'sd1; end
         3'd4: begin dr =  2'sd0; dc =  2'sd1; end
         3'd5: begin dr =  2'sd1; dc = -2'sd1; end
         3'd6: begin dr =  2'sd1; dc =  2'sd0; end
         default: begin dr = 2'sd1; dc = 2'sd1; end
      endcase
   end

   logic signed [RowBits+1:0] nr;
   logic signed [ColBits+1:0] nc;
   logic n_in_board;
   logic [AddrBits-1:0] n_addr;
   always_comb begin
      nr = $signed({2'b00, row_ff}) + (RowBits+2)'(dr);
      nc = $signed({2'b00, col_ff}) + (ColBits+2)'(dc);
      n_in_board = (nr >= 0) && (nc >= 0) && (nr < $signed((RowBits+2)'(h_use)))
                   && (nc < $signed((ColBits+2)'(w_use)));
      n_addr = AddrBits'(addr_ff + AddrBits'(dc)
               + AddrBits'(dr * $signed({1'b0, w_use})));
   end

   // rule
   logic nxt_bit;
   always_comb nxt_bit = (cnt_ff == lge_pkg::BirthCount) ||
                         (center_ff && cnt_ff == lge_pkg::SurviveCount);

   // memories
   logic cs_we, ns_we;
   logic [AddrBits-1:0] cs_wa, cs_ra, ns_wa;
   logic cs_wd, ns_wd, cs_rd, ns_rd;

   lge_ram #(.Width(1), .Depth(Depth)) u_cell (
      .clock, .wr_en(cs_we), .wr_addr(cs_wa), .wr_data(cs_wd),
      .rd_addr(cs_ra), .rd_data(cs_rd));
   lge_ram #(.Width(1), .Depth(Depth)) u_next (
      .clock, .wr_en(ns_we), .wr_addr(ns_wa), .wr_data(ns_wd),
      .rd_addr(addr_ff), .rd_data(ns_rd));

   always_comb begin
      row_in = row_ff; col_in = col_ff; addr_in = addr_ff;
      step_in = step_ff; cnt_in = cnt_ff; center_in = center_ff;
      val_in = val_ff; bad_in = bad_ff; idx_in = idx_ff;
      clr_done_in = clr_done_ff;
      rd_nb_in = 1'b0; rd_ct_in = 1'b0; rd_cp_in = 1'b0; cp_addr_in = addr_ff;
      cs_we = 1'b0; cs_wa = addr_ff; cs_wd = 1'b0; cs_ra = addr_ff;
      ns_we = 1'b0; ns_wa = addr_ff; ns_wd = nxt_bit;

      if (rd_nb_ff) cnt_in = cnt_in + lge_pkg::CountBits'(cs_rd);
      if (rd_ct_ff) center_in = cs_rd;
      if (rd_cp_ff) begin
         cs_we = 1'b1; cs_wa = cp_addr_ff; cs_wd = ns_rd;
      end

      if (ctl.step_first) begin
         step_in = '0; cnt_in = '0;
      end

      case (ctl.cmd)
         lge_pkg::DP_CLEAR: begin
            cs_we = !clr_done_ff; cs_wa = addr_ff; cs_wd = 1'b0;
            addr_in = addr_ff + AddrBits'(1);
            if (32'(addr_ff) == Depth - 1) clr_done_in = 1'b1;
         end
         lge_pkg::DP_LOAD: begin
            idx_in = req_cell_index;
            val_in = req_cell_value;
            bad_in = 32'(req_cell_index) >= 32'(total);
            addr_in = AddrBits'(req_cell_index);
            row_in = '0; col_in = '0;
         end
         lge_pkg::DP_NEIGH: begin
            cs_ra = n_addr;
            rd_nb_in = n_in_board;
            step_in = step_ff + 4'd1;
         end
         lge_pkg::DP_CENTER: begin
            cs_ra = addr_ff;
            rd_ct_in = 1'b1;
         end
         lge_pkg::DP_WRITE_NEXT: begin
            ns_we = 1'b1;
         end
         lge_pkg::DP_COPY_RD: begin
            rd_cp_in = 1'b1; cp_addr_in = addr_ff;
         end
         default: ;
      endcase

      if (ctl.set_write) begin
         cs_we = 1'b1; cs_wa = addr_ff; cs_wd = val_ff;
      end

      if (ctl.div_step) begin
         if (div_done) col_in = ColBits'(idx_ff);
         else begin
            idx_in = idx_ff - IdxBits'(w_use);
            row_in = row_ff + RowBits'(1);
         end
      end

      if (ctl.cell_first) begin
         addr_in = '0; row_in = '0; col_in = '0;
      end else if (ctl.cell_next) begin
         addr_in = addr_ff + AddrBits'(1);
         if (32'(col_ff) + 1 >= 32'(w_use)) begin
            col_in = '0; row_in = row_ff + RowBits'(1);
         end else col_in = col_ff + ColBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_done_ff <= 1'b0;
         addr_ff <= '0;
         rd_nb_ff <= 1'b0; rd_ct_ff <= 1'b0; rd_cp_ff <= 1'b0;
      end else begin
         clr_done_ff <= clr_done_in;
         addr_ff <= addr_in;
         rd_nb_ff <= rd_nb_in; rd_ct_ff <= rd_ct_in; rd_cp_ff <= rd_cp_in;
      end
      step_ff <= step_in; cnt_ff <= cnt_in; center_ff <= center_in;
      val_ff <= val_in; bad_ff <= bad_in; cp_addr_ff <= cp_addr_in;
      idx_ff <= idx_in; row_ff <= row_in; col_ff <= col_in;
   end

   always_comb begin
      sts.clear_done = clr_done_ff;
      sts.step_last = (step_ff == 4'd8);
      sts.cell_last = (32'(addr_ff) + 1 >= 32'(total));
      sts.bad_index = bad_ff;
      sts.div_done = div_done;
      res_cell_state = center_ff;
      res_count = cnt_ff;
   end
endmodule
`default_nettype wire

// File: sv/lge_ctrl.sv
`default_nettype none
module lge_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   output lge_pkg::ctl_type      ctl,
   input  wire lge_pkg::sts_type sts,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [1:0]       req_operation,
   input  wire logic             res_cell_state,
   input  wire logic [3:0]       res_count,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_cell_state,
   output logic [3:0]            rsp_neighbour_count,
   output logic                  rsp_index_error
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_RD_NB, S_RD_CT, S_RD_WAIT, S_RD_DONE, S_SET,
      S_ADV_NB, S_ADV_CT, S_ADV_WAIT, S_ADV_WR, S_CP_RD, S_CP_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic rv_ff, rv_in, rs_ff, rs_in, re_ff, re_in;
   logic [3:0] rc_ff, rc_in;

   always_comb begin
      state_in = state_ff; op_in = op_ff;
      rv_in = rv_ff; rs_in = rs_ff; re_in = re_ff; rc_in = rc_ff;
      ctl = '{cmd: lge_pkg::DP_IDLE, step_first: 1'b0, cell_first: 1'b0,
              cell_next: 1'b0, set_write: 1'b0, div_step: 1'b0};
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      req_ready = (state_ff == S_IDLE) && !rv_ff;

      case (state_ff)
         S_CLEAR: begin
            ctl.cmd = lge_pkg::DP_CLEAR;
            if (sts.clear_done) state_in = S_IDLE;
         end
         S_IDLE: if (req_valid && req_ready) begin
            op_in = req_operation;
            ctl.step_first = 1'b1;
            if (req_operation == lge_pkg::OP_ADVANCE) begin
               ctl.cell_first = 1'b1; state_in = S_ADV_NB;
            end else if (req_operation == lge_pkg::OP_NONE) begin
               rv_in = 1'b1; rs_in = 1'b0; rc_in = '0; re_in = 1'b0;
            end else begin
               ctl.cmd = lge_pkg::DP_LOAD; state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (sts.bad_index) begin
               state_in = S_IDLE;
               rv_in = 1'b1; rs_in = 1'b0; rc_in = '0; re_in = 1'b1;
            end else begin
               // datapath reduces index into row/col, one row a cycle
               ctl.div_step = 1'b1;
               if (sts.div_done) begin
                  if (op_ff == lge_pkg::OP_SET) state_in = S_SET;
                  else state_in = S_RD_NB;
               end
            end
         end
         S_RD_NB: begin
            if (sts.step_last) state_in = S_RD_CT;
            else ctl.cmd = lge_pkg::DP_NEIGH;
         end
         S_SET: begin
            ctl.set_write = 1'b1; state_in = S_RD_CT;
         end
         S_RD_CT: begin
            ctl.cmd = lge_pkg::DP_CENTER; state_in = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            state_in = S_RD_DONE;
         end
         S_RD_DONE: begin
            state_in = S_IDLE;
         end
         S_ADV_NB: begin
            if (sts.step_last) state_in = S_ADV_CT;
            else ctl.cmd = lge_pkg::DP_NEIGH;
         end
         S_ADV_CT: begin
            ctl.cmd = lge_pkg::DP_CENTER; state_in = S_ADV_WAIT;
         end
         S_ADV_WAIT: state_in = S_ADV_WR;
         S_ADV_WR: begin
            ctl.cmd = lge_pkg::DP_WRITE_NEXT;
            ctl.step_first = 1'b1;
            if (sts.cell_last) begin
               ctl.cell_first = 1'b1; state_in = S_CP_RD;
            end else begin
               ctl.cell_next = 1'b1; state_in = S_ADV_NB;
            end
         end
         S_CP_RD: begin
            ctl.cmd = lge_pkg::DP_COPY_RD;
            if (sts.cell_last) state_in = S_CP_WAIT;
            else ctl.cell_next = 1'b1;
         end
         S_CP_WAIT: begin
            state_in = S_IDLE;
            rv_in = 1'b1; rs_in = 1'b0; rc_in = '0; re_in = 1'b0;
         end
         default: state_in = S_IDLE;
      endcase

      if (state_ff == S_RD_DONE) begin
         rv_in = 1'b1; rs_in = res_cell_state; re_in = 1'b0;
         rc_in = (op_ff == lge_pkg::OP_READ) ? res_count : 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      op_ff <= op_in; rs_ff <= rs_in; re_ff <= re_in; rc_ff <= rc_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_cell_state = rs_ff;
   assign rsp_neighbour_count = rc_ff;
   assign rsp_index_error = re_ff;
endmodule
`default_nettype wire

// File: sv/life_generation_engine.sv
`default_nettype none
// channel  | dir | handshake     | payload
// req      | in  | valid/ready   | operation, cell_index, cell_value
// rsp      | out | valid/ready   | cell_state, neighbour_count, index_error
// csr      | in  | write enable  | csr_index, csr_data
// Set/read: index reduced to row/col at one row a cycle (row = index / width).
// Set writes the cell, then reads its state back; read makes 8 neighbour reads
// and one center read. A bad index answers from S_DIV without the reduction.
// Advance: neighbour reads, center read and next-gen write for each cell, then
// a copy back of each cell, on the single cell store port.
// After reset a clearing pass over all MaxWidth*MaxHeight cells blocks items.
// One item at a time; a waiting result blocks the next item.
module life_generation_engine #(
   parameter int MaxWidth  = lge_pkg::MaxWidthDefault,
   parameter int MaxHeight = lge_pkg::MaxHeightDefault
) (
   input wire logic                                clock,
   input wire logic                                reset,
   lge_req_if.sink                                 req,
   lge_rsp_if.source                               rsp,
   input wire logic                                csr_write,
   input wire logic [lge_pkg::CsrAddrBits-1:0]     csr_index,
   input wire logic [lge_pkg::CsrDataBits-1:0]     csr_data
);
   logic [lge_pkg::WidthRegBits-1:0]  width_ff;
   logic [lge_pkg::HeightRegBits-1:0] height_ff;
   lge_pkg::ctl_type ctl;
   lge_pkg::sts_type sts;
   logic res_cell_state;
   logic [lge_pkg::CountBits-1:0] res_count;
   logic ctl_ready, ctl_rsp_valid, ctl_rs, ctl_re;
   logic [3:0] ctl_rc;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= lge_pkg::WidthReset;
         height_ff <= lge_pkg::HeightReset;
      end else if (csr_write) begin
         if (csr_index == lge_pkg::CSR_WIDTH) width_ff <= csr_data;
         else height_ff <= lge_pkg::HeightRegBits'(csr_data);
      end
   end

   lge_datapath #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight)) u_dp (
      .clock, .reset, .ctl, .sts,
      .req_cell_index(req.cell_index),
      .req_cell_value(req.cell_value), .width_reg(width_ff), .height_reg(height_ff),
      .res_cell_state, .res_count);

   lge_ctrl u_ctrl (
      .clock, .reset, .ctl, .sts,
      .req_valid(req.valid), .req_ready(ctl_ready), .req_operation(req.operation),
      .res_cell_state, .res_count,
      .rsp_valid(ctl_rsp_valid), .rsp_ready(rsp.ready),
      .rsp_cell_state(ctl_rs), .rsp_neighbour_count(ctl_rc),
      .rsp_index_error(ctl_re));

   assign req.ready = ctl_ready;
   assign rsp.valid = ctl_rsp_valid;
   assign rsp.cell_state = ctl_rs;
   assign rsp.neighbour_count = ctl_rc;
   assign rsp.index_error = ctl_re;
endmodule
`default_nettype wire

// File: sv/lge_checker.sv
`default_nettype none
module lge_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_cell_state,
   input wire logic [3:0] rsp_neighbour_count,
   input wire logic       rsp_index_error
);
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_neighbour_count <= 4'd8) else $error("count above 8");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_index_error |-> !rsp_cell_state && rsp_neighbour_count == 4'd0)
      else $error("error result not clean");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !(req_valid && req_ready))
      else $error("item taken while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
endmodule

bind life_generation_engine lge_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_cell_state(rsp.cell_state),
   .rsp_neighbour_count(rsp.neighbour_count), .rsp_index_error(rsp.index_error));
`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
   localparam int BoardCells = lge_pkg::MaxWidthDefault * lge_pkg::MaxHeightDefault;
   localparam int CycleLimit = 8000000;

   typedef struct packed {
      logic       cell_state;
      logic [3:0] neighbour_count;
      logic       index_error;
   } cell_result_type;

   typedef struct {
      lge_pkg::op_type op;
      int              index;
      bit              value;
      bit              typed;
      cell_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [lge_pkg::CsrAddrBits-1:0] csr_index = '0;
   logic [lge_pkg::CsrDataBits-1:0] csr_data = '0;

   lge_req_if req_ch ();
   lge_rsp_if rsp_ch ();

   life_generation_engine dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // board shadow
   bit                                life_board [BoardCells];
   logic [lge_pkg::WidthRegBits-1:0]  width_reg;
   logic [lge_pkg::HeightRegBits-1:0] height_reg;

   cell_result_type pending_results [$];
   int error_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_request = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   function automatic int used_width();
      if (width_reg == 0) return 1;
      if (width_reg > lge_pkg::MaxWidthDefault) return lge_pkg::MaxWidthDefault;
      return width_reg;
   endfunction

   function automatic int used_height();
      if (height_reg == 0) return 1;
      if (height_reg > lge_pkg::MaxHeightDefault) return lge_pkg::MaxHeightDefault;
      return height_reg;
   endfunction

   function automatic int live_neighbours(int idx, int w, int h);
      int row, col, r, c, n;
      row = idx / w;
      col = idx % w;
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            r = row + dr;
            c = col + dc;
            if (dr == 0 && dc == 0) continue;
            if (r < 0 || c < 0 || r >= h || c >= w) continue;
            n += life_board[r * w + c];
         end
      end
      return n;
   endfunction

   // applies one item to the shadow board and returns its result
   function automatic cell_result_type apply_item(lge_pkg::op_type op, int idx, bit value);
      cell_result_type res;
      bit next_board [BoardCells];
      int w, h, total, n;
      w = used_width();
      h = used_height();
      total = w * h;
      res = '0;
      if (op == lge_pkg::OP_SET || op == lge_pkg::OP_READ) begin
         if (idx >= total) begin
            res.index_error = 1'b1;
         end else begin
            if (op == lge_pkg::OP_SET) life_board[idx] = value;
            else res.neighbour_count = 4'(live_neighbours(idx, w, h));
            res.cell_state = life_board[idx];
         end
      end else if (op == lge_pkg::OP_ADVANCE) begin
         for (int i = 0; i < total; i++) begin
            n = live_neighbours(i, w, h);
            next_board[i] = (n == lge_pkg::BirthCount) ||
                            (life_board[i] && n == lge_pkg::SurviveCount);
         end
         for (int i = 0; i < total; i++) life_board[i] = next_board[i];
      end
      return res;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch: %s got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   // drive one item; valid stays high after acceptance unless a gap follows
   task automatic send_item(lge_pkg::op_type op, int idx, bit value, bit typed = 0,
                            cell_result_type typed_result = '0);
      cell_result_type predicted;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_ch.valid      <= 1'b1;
      req_ch.operation  <= op;
      req_ch.cell_index <= lge_pkg::IndexBits'(idx);
      req_ch.cell_value <= value;
      do @(posedge clock); while (!req_ch.ready);
      predicted = apply_item(op, idx, value);
      pending_results.push_back(typed ? typed_result : predicted);
   endtask

   task automatic write_reg(logic [lge_pkg::CsrAddrBits-1:0] idx, int data);
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= lge_pkg::CsrDataBits'(data);
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == lge_pkg::CSR_WIDTH) width_reg = lge_pkg::WidthRegBits'(data);
      else height_reg = lge_pkg::HeightRegBits'(data);
   endtask

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_request != hold_seen) begin
         hold_seen <= hold_request;
         hold_left <= 400;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // result side: random stall, checking
   always @(posedge clock) begin
      cell_result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("life_generation_engine test failed");
         $finish;
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", 1, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.cell_state !== want.cell_state)
               report_mismatch("cell_state", rsp_ch.cell_state, want.cell_state);
            if (rsp_ch.neighbour_count !== want.neighbour_count)
               report_mismatch("neighbour_count", rsp_ch.neighbour_count,
                               want.neighbour_count);
            if (rsp_ch.index_error !== want.index_error)
               report_mismatch("index_error", rsp_ch.index_error, want.index_error);
         end
      end
      if (hold_left > 0) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   stim_row_type directed [] = '{
      '{lge_pkg::OP_READ,    0,    0, 1, '{1'b0, 4'd0, 1'b0}},
      '{lge_pkg::OP_READ,    4799, 0, 1, '{1'b0, 4'd0, 1'b0}},
      '{lge_pkg::OP_READ,    4800, 0, 1, '{1'b0, 4'd0, 1'b1}},
      '{lge_pkg::OP_READ,    8191, 0, 1, '{1'b0, 4'd0, 1'b1}},
      '{lge_pkg::OP_SET,     8191, 1, 1, '{1'b0, 4'd0, 1'b1}},
      '{lge_pkg::OP_NONE,    8191, 1, 1, '{1'b0, 4'd0, 1'b0}},
      '{lge_pkg::OP_SET,     0,    1, 1, '{1'b1, 4'd0, 1'b0}},
      '{lge_pkg::OP_SET,     1,    1, 1, '{1'b1, 4'd0, 1'b0}},
      '{lge_pkg::OP_SET,     120,  1, 1, '{1'b1, 4'd0, 1'b0}},
      '{lge_pkg::OP_READ,    121,  0, 0, '0},
      '{lge_pkg::OP_SET,     4799, 1, 1, '{1'b1, 4'd0, 1'b0}},
      '{lge_pkg::OP_READ,    4798, 0, 0, '0},
      '{lge_pkg::OP_SET,     4799, 0, 1, '{1'b0, 4'd0, 1'b0}},
      '{lge_pkg::OP_SET,     4798, 0, 0, '0},
      '{lge_pkg::OP_ADVANCE, 8191, 1, 1, '{1'b0, 4'd0, 1'b0}},
      '{lge_pkg::OP_READ,    0,    0, 0, '0},
      '{lge_pkg::OP_READ,    121,  0, 0, '0},
      '{lge_pkg::OP_READ,    1,    0, 0, '0}
   };

   initial begin
      int phase_send [4];
      int phase_recv [4];
      int w_set, h_set, total, pick, idx;
      phase_send = '{0, 82, 0, 19};
      phase_recv = '{0, 0, 82, 19};
      req_ch.valid = 1'b0;
      req_ch.operation = lge_pkg::OP_NONE;
      req_ch.cell_index = '0;
      req_ch.cell_value = 1'b0;
      rsp_ch.ready = 1'b0;
      width_reg = lge_pkg::WidthReset;
      height_reg = lge_pkg::HeightReset;
      foreach (life_board[i]) life_board[i] = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_item(directed[i].op, directed[i].index, directed[i].value,
                   directed[i].typed, directed[i].result);

      // register extremes: clamped above, clamped below
      write_reg(lge_pkg::CSR_WIDTH, 255);
      write_reg(lge_pkg::CSR_HEIGHT, 127);
      send_item(lge_pkg::OP_SET, 8191, 1'b1);
      send_item(lge_pkg::OP_SET, 8190, 1'b1);
      send_item(lge_pkg::OP_SET, 8063, 1'b1);
      send_item(lge_pkg::OP_ADVANCE, 0, 1'b0);
      send_item(lge_pkg::OP_READ, 8191, 1'b0);
      write_reg(lge_pkg::CSR_WIDTH, 0);
      write_reg(lge_pkg::CSR_HEIGHT, 0);
      send_item(lge_pkg::OP_READ, 1, 1'b0, 1, '{1'b0, 4'd0, 1'b1});
      send_item(lge_pkg::OP_SET, 0, 1'b1);
      send_item(lge_pkg::OP_ADVANCE, 0, 1'b0);
      send_item(lge_pkg::OP_READ, 0, 1'b0);

      for (int phase = 0; phase < 4; phase++) begin
         for (int part = 0; part < 2; part++) begin
            if ($urandom_range(0, 9) == 0) begin
               w_set = $urandom_range(129, 255);
               h_set = $urandom_range(0, 4);
            end else if ($urandom_range(0, 9) == 0) begin
               w_set = $urandom_range(0, 3);
               h_set = $urandom_range(65, 127);
            end else begin
               w_set = $urandom_range(0, 10);
               h_set = $urandom_range(0, 8);
            end
            write_reg(lge_pkg::CSR_WIDTH, w_set);
            write_reg(lge_pkg::CSR_HEIGHT, h_set);
            send_idle_pct = phase_send[phase];
            recv_stall_pct = phase_recv[phase];
            if (phase == 0 && part == 0) hold_request++;
            total = used_width() * used_height();
            repeat (11) begin
               pick = $urandom_range(0, 99);
               idx = $urandom_range(0, total - 1);
               if (pick < 40)
                  send_item(lge_pkg::OP_SET, idx, ($urandom_range(0, 99) < 55));
               else if (pick < 70)
                  send_item(lge_pkg::OP_READ, idx, $urandom_range(0, 1));
               else if (pick < 85)
                  send_item(lge_pkg::OP_ADVANCE, $urandom_range(0, 8191),
                            $urandom_range(0, 1));
               else if (pick < 94)
                  send_item(lge_pkg::op_type'($urandom_range(0, 1)),
                            $urandom_range(total, 8191), $urandom_range(0, 1));
               else
                  send_item(lge_pkg::OP_NONE, $urandom_range(0, 8191), $urandom_range(0, 1));
            end
         end
      end

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("life_generation_engine test passed");
      else
         $display("life_generation_engine test failed");
      $finish;
   end
endmodule
`default_nettype wire
